// ===== design/playfair_digraph_encryptor_macros.svh =====
// ---------------------------------------------------------------------------
// Playfair digraph encryptor assertion macros
// Immediate-cycle and next-cycle implication checks, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_MACROS_SVH

`ifndef SYNTHESIS
`define PFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PFD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/pfd_pkg.sv =====
// ---------------------------------------------------------------------------
// Playfair digraph encryptor package
// Letter codes, command codes, sequencer states and square geometry helpers.
// ---------------------------------------------------------------------------
package pfd_pkg;

  localparam int unsigned SqSide     = 5;
  localparam int unsigned SqCells    = 25;
  localparam int unsigned NumLetters = 26;

  localparam logic [4:0] LetI       = 5'd8;
  localparam logic [4:0] LetJ       = 5'd9;
  localparam logic [4:0] LetX       = 5'd23;
  localparam logic [4:0] LastLetter = 5'd25;
  localparam logic [4:0] FullCount  = 5'd25;

  typedef enum logic [1:0] {
    CMD_KEY    = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS_A,
    ST_POS_B,
    ST_KEY_A,
    ST_KEY_B,
    ST_PUT
  } state_e;

  function automatic logic [4:0] fold_j(input logic [4:0] l);
    return (l == LetJ) ? LetI : l;
  endfunction

  // Row of a square cell, by comparison against the row starts.
  function automatic logic [2:0] cell_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [4:0] row_base(input logic [2:0] r);
    return {r, 2'b00} + {2'b00, r};
  endfunction

  function automatic logic [2:0] step_wrap(input logic [2:0] v);
    return (v == 3'd4) ? 3'd0 : v + 3'd1;
  endfunction

endpackage

// ===== design/pfd_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module pfd_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 25
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/pfd_rule.sv =====
// ---------------------------------------------------------------------------
// Playfair digraph rule unit
// Maps the square cells of two letters to the cells of their cipher letters.
// ---------------------------------------------------------------------------
module pfd_rule (
  input  logic [4:0] pos_a_i,
  input  logic [4:0] pos_b_i,
  output logic [4:0] cell_a_o,
  output logic [4:0] cell_b_o
);

  logic [2:0] ra, rb, ca, cb;
  logic [2:0] ra_n, rb_n, ca_n, cb_n;
  logic [4:0] ca_w, cb_w;

  always_comb begin
    ra   = pfd_pkg::cell_row(pos_a_i);
    rb   = pfd_pkg::cell_row(pos_b_i);
    ca_w = pos_a_i - pfd_pkg::row_base(ra);
    cb_w = pos_b_i - pfd_pkg::row_base(rb);
    ca   = ca_w[2:0];
    cb   = cb_w[2:0];
    ra_n = ra;
    rb_n = rb;
    ca_n = ca;
    cb_n = cb;
    // A pair in one cell (x with x) counts as the same row.
    if (ra == rb) begin
      ca_n = pfd_pkg::step_wrap(ca);
      cb_n = pfd_pkg::step_wrap(cb);
    end else if (ca == cb) begin
      ra_n = pfd_pkg::step_wrap(ra);
      rb_n = pfd_pkg::step_wrap(rb);
    end else begin
      ca_n = cb;
      cb_n = ca;
    end
    cell_a_o = pfd_pkg::row_base(ra_n) + {2'b00, ca_n};
    cell_b_o = pfd_pkg::row_base(rb_n) + {2'b00, cb_n};
  end

endmodule

// ===== design/playfair_digraph_encryptor.sv =====
// ---------------------------------------------------------------------------
// Playfair digraph encryptor
// Builds a 5x5 key square from key letters and encrypts text digraphs.
// ---------------------------------------------------------------------------
//  Channel   Dir  Payload
//  s_axis    in   tuser[1:0] cmd, tdata[4:0] letter
//  m_axis    out  tdata[4:0] cipher_first, tdata[9:5] cipher_second
//
// Key letters and empty commands are handled in the idle state. The finish
// command walks the alphabet, one letter per cycle, through the square write
// port. A digraph passes through two reads of the position RAM and two reads
// of the key square RAM, each with registered read data, then the output
// register. An output register held full by the sink stalls the sequencer in
// its last step. Reset clears all control state; the RAMs need no clearing.
// ---------------------------------------------------------------------------
`include "playfair_digraph_encryptor_macros.svh"

module playfair_digraph_encryptor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [4:0] letter
  input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [4:0] cipher_first, [9:5] cipher_second
);

  pfd_pkg::state_e state_q, state_d;

  logic [4:0]  fill_q, fill_d;
  logic [25:0] used_q, used_d;
  logic        done_q, done_d;
  logic [4:0]  pend_q, pend_d;
  logic        pend_v_q, pend_v_d;
  logic [4:0]  walk_q, walk_d;
  logic [4:0]  a_q, a_d, b_q, b_d;
  logic [4:0]  pa_q, cellb_q, first_q;
  logic        out_v_q, out_v_d;
  logic [4:0]  out_first_q, out_second_q;

  logic        accept;
  logic [1:0]  cmd;
  logic [4:0]  raw, text_l;
  logic        raw_ok;
  logic [4:0]  place_l;
  logic        place_try, place_en;
  logic [31:0] used_ext;
  logic [4:0]  pos_raddr, pos_rdata;
  logic [4:0]  key_raddr, key_rdata;
  logic [4:0]  cell_a, cell_b;
  logic        out_load;

  assign cmd    = s_axis_tuser;
  assign raw    = s_axis_tdata[4:0];
  assign raw_ok = (raw <= pfd_pkg::LastLetter);
  assign text_l = pfd_pkg::fold_j(raw);
  assign accept = s_axis_tvalid & s_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfd_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd == pfd_pkg::CMD_FINISH && !done_q) begin
            state_d = pfd_pkg::ST_FILL;
          end else if (cmd == pfd_pkg::CMD_TEXT && done_q && raw_ok && pend_v_q) begin
            state_d = pfd_pkg::ST_POS_A;
          end else if (cmd == pfd_pkg::CMD_END && done_q && pend_v_q) begin
            state_d = pfd_pkg::ST_POS_A;
          end
        end
      end
      pfd_pkg::ST_FILL: begin
        if (walk_q == pfd_pkg::LastLetter) state_d = pfd_pkg::ST_IDLE;
      end
      pfd_pkg::ST_POS_A: state_d = pfd_pkg::ST_POS_B;
      pfd_pkg::ST_POS_B: state_d = pfd_pkg::ST_KEY_A;
      pfd_pkg::ST_KEY_A: state_d = pfd_pkg::ST_KEY_B;
      pfd_pkg::ST_KEY_B: state_d = pfd_pkg::ST_PUT;
      pfd_pkg::ST_PUT: begin
        if (out_load) state_d = pfd_pkg::ST_IDLE;
      end
      default: state_d = pfd_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = (state_q == pfd_pkg::ST_IDLE);
    out_load      = (state_q == pfd_pkg::ST_PUT) && (!out_v_q || m_axis_tready);
    pos_raddr     = (state_q == pfd_pkg::ST_POS_A) ? a_q : b_q;
    key_raddr     = (state_q == pfd_pkg::ST_KEY_A) ? cell_a : cellb_q;
    place_l       = (state_q == pfd_pkg::ST_FILL) ? walk_q : text_l;
    place_try     = ((state_q == pfd_pkg::ST_IDLE) && accept && cmd == pfd_pkg::CMD_KEY
                     && !done_q && raw_ok)
                  || ((state_q == pfd_pkg::ST_FILL) && walk_q != pfd_pkg::LetJ);
  end

  assign used_ext = {6'b0, used_q};
  assign place_en = place_try && (fill_q < pfd_pkg::FullCount) && !used_ext[place_l];

  // Square bookkeeping and the pending text letter.
  always_comb begin
    fill_d   = fill_q;
    used_d   = used_q;
    done_d   = done_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    walk_d   = walk_q;
    a_d      = a_q;
    b_d      = b_q;
    if (place_en) begin
      fill_d = fill_q + 5'd1;
      used_d = used_q | 26'(32'd1 << place_l);
    end
    if (state_q == pfd_pkg::ST_FILL) begin
      walk_d = walk_q + 5'd1;
      if (walk_q == pfd_pkg::LastLetter) done_d = 1'b1;
    end
    if (state_q == pfd_pkg::ST_IDLE && accept) begin
      case (cmd)
        pfd_pkg::CMD_FINISH: walk_d = 5'd0;
        pfd_pkg::CMD_TEXT: begin
          if (done_q && raw_ok) begin
            if (!pend_v_q) begin
              pend_d   = text_l;
              pend_v_d = 1'b1;
            end else begin
              a_d = pend_q;
              // A doubled letter pairs with x and stays pending.
              if (text_l == pend_q) begin
                b_d = pfd_pkg::LetX;
              end else begin
                b_d      = text_l;
                pend_d   = 5'd0;
                pend_v_d = 1'b0;
              end
            end
          end
        end
        pfd_pkg::CMD_END: begin
          if (done_q && pend_v_q) begin
            a_d      = pend_q;
            b_d      = pfd_pkg::LetX;
            pend_d   = 5'd0;
            pend_v_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (out_load)           out_v_d = 1'b1;
    else if (m_axis_tready) out_v_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pfd_pkg::ST_IDLE;
      fill_q   <= 5'd0;
      used_q   <= 26'd0;
      done_q   <= 1'b0;
      pend_q   <= 5'd0;
      pend_v_q <= 1'b0;
      walk_q   <= 5'd0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      used_q   <= used_d;
      done_q   <= done_d;
      pend_q   <= pend_d;
      pend_v_q <= pend_v_d;
      walk_q   <= walk_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    if (state_q == pfd_pkg::ST_POS_B) pa_q <= pos_rdata;
    if (state_q == pfd_pkg::ST_KEY_A) cellb_q <= cell_b;
    if (state_q == pfd_pkg::ST_KEY_B) first_q <= key_rdata;
    if (out_load) begin
      out_first_q  <= first_q;
      out_second_q <= key_rdata;
    end
  end

  // Square index of each placed letter.
  pfd_ram #(
    .Width(5),
    .Depth(pfd_pkg::NumLetters)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (place_en),
    .waddr_i(place_l),
    .wdata_i(fill_q),
    .raddr_i(pos_raddr),
    .rdata_o(pos_rdata)
  );

  // Key square in row-major order.
  pfd_ram #(
    .Width(5),
    .Depth(pfd_pkg::SqCells)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (place_en),
    .waddr_i(fill_q),
    .wdata_i(place_l),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

  pfd_rule u_rule (
    .pos_a_i (pa_q),
    .pos_b_i (pos_rdata),
    .cell_a_o(cell_a),
    .cell_b_o(cell_b)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b0, out_second_q, out_first_q};

  `PFD_ASSERT_NOW(a_done_full, clk_i, rst_ni, done_q, fill_q == pfd_pkg::FullCount)
  `PFD_ASSERT_NOW(a_pend_after_done, clk_i, rst_ni, pend_v_q, done_q)
  `PFD_ASSERT_NOW(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= pfd_pkg::FullCount)
  `PFD_ASSERT_NEXT(a_put_shows, clk_i, rst_ni, out_load, m_axis_tvalid)

endmodule
